/* rtl/core/round_robin_dispatcher_unit_assert.svh */
// Assertion macros used by the dispatcher top level.
`ifndef ROUND_ROBIN_DISPATCHER_UNIT_ASSERT_SVH
`define ROUND_ROBIN_DISPATCHER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RRD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RRD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/rrd_pkg.sv */
// Types and codes shared by the dispatcher controller, datapath and top level.
package rrd_pkg;

	typedef enum logic [1:0] {
		KIND_DISPATCH = 2'd0,
		KIND_EMPTY    = 2'd1,
		KIND_FULL     = 2'd2
	} kind_t;

	typedef enum logic {
		OP_ENQUEUE = 1'b0,
		OP_SLICE   = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_EMPTY,
		S_FULL
	} rrd_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic  push;
		logic  issue_rd;
		logic  commit;
		logic  flag_load;
		kind_t flag_kind;
	} rrd_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic full;
		logic empty;
		logic out_free;
	} rrd_stat_t;

endpackage

/* rtl/core/rrd_ctrl.sv */
// Controller state machine of the dispatcher.
module rrd_ctrl
	import rrd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      op,
	input  rrd_stat_t stat,
	output logic      in_stall,
	output rrd_cmd_t  cmd
);

	rrd_state_t state_q;
	rrd_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (op == OP_SLICE) begin
						state_d = stat.empty ? S_EMPTY : S_READ;
					end else if (stat.full) begin
						state_d = S_FULL;
					end
				end
			end
			S_READ, S_EMPTY, S_FULL: begin
				if (stat.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_stall      = (state_q != S_IDLE);
		cmd.push      = (state_q == S_IDLE) && in_valid && (op == OP_ENQUEUE) && !stat.full;
		cmd.issue_rd  = (state_q == S_IDLE) && in_valid && (op == OP_SLICE) && !stat.empty;
		cmd.commit    = (state_q == S_READ) && stat.out_free;
		cmd.flag_load = ((state_q == S_EMPTY) || (state_q == S_FULL)) && stat.out_free;
		cmd.flag_kind = (state_q == S_FULL) ? KIND_FULL : KIND_EMPTY;
	end

endmodule

/* rtl/core/rrd_dpath.sv */
// Datapath of the dispatcher: job queue memory, pointers, quantum and result register.
module rrd_dpath
	import rrd_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic [7:0]  job_id,
	input  logic [15:0] service_time,
	input  rrd_cmd_t    cmd,
	output rrd_stat_t   stat,
	input  logic        out_stall,
	output logic        out_valid,
	output logic [1:0]  kind,
	output logic [7:0]  run_id,
	output logic [15:0] time_needed,
	output logic        finished,
	output logic [15:0] time_left,
	output logic        queue_empty
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);
	localparam logic [CW-1:0] CNT_ONE  = CW'(1);

	logic [7:0]    ids_mem   [QUEUE_DEPTH];
	logic [15:0]   times_mem [QUEUE_DEPTH];

	logic [PW-1:0] head_q;
	logic [PW-1:0] tail_q;
	logic [CW-1:0] count_q;
	logic [15:0]   quantum_q;
	logic [7:0]    rd_id_q;
	logic [15:0]   rd_time_q;
	logic          out_valid_q;
	kind_t         kind_q;
	logic [7:0]    run_id_q;
	logic [15:0]   time_needed_q;
	logic          finished_q;
	logic [15:0]   time_left_q;
	logic          queue_empty_q;

	logic          fin;
	logic [15:0]   left;
	logic          wr_en;
	logic [7:0]    wr_id;
	logic [15:0]   wr_time;
	logic [PW-1:0] head_nxt;
	logic [PW-1:0] tail_nxt;

	assign head_nxt = (head_q == PTR_LAST) ? '0 : head_q + PW'(1);
	assign tail_nxt = (tail_q == PTR_LAST) ? '0 : tail_q + PW'(1);

	assign fin  = (rd_time_q <= quantum_q);
	assign left = rd_time_q - quantum_q;

	// A job that outlives its slice is written back at the tail.
	assign wr_en   = cmd.push || (cmd.commit && !fin);
	assign wr_id   = cmd.push ? job_id : rd_id_q;
	assign wr_time = cmd.push ? service_time : left;

	assign stat.full     = (count_q == CNT_FULL);
	assign stat.empty    = (count_q == '0);
	assign stat.out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ids_mem[tail_q]   <= wr_id;
			times_mem[tail_q] <= wr_time;
		end
		if (cmd.issue_rd) begin
			rd_id_q   <= ids_mem[head_q];
			rd_time_q <= times_mem[head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			tail_q    <= '0;
			count_q   <= '0;
			quantum_q <= 16'd1;
		end else begin
			if (cfg_we) begin
				quantum_q <= cfg_wdata;
			end
			if (wr_en) begin
				tail_q <= tail_nxt;
			end
			if (cmd.commit) begin
				head_q <= head_nxt;
			end
			if (cmd.push) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.commit && fin) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit || cmd.flag_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			kind_q        <= KIND_DISPATCH;
			run_id_q      <= rd_id_q;
			time_needed_q <= rd_time_q;
			finished_q    <= fin;
			time_left_q   <= fin ? 16'd0 : left;
			queue_empty_q <= fin && (count_q == CNT_ONE);
		end else if (cmd.flag_load) begin
			kind_q        <= cmd.flag_kind;
			run_id_q      <= 8'd0;
			time_needed_q <= 16'd0;
			finished_q    <= 1'b0;
			time_left_q   <= 16'd0;
			queue_empty_q <= stat.empty;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign run_id      = run_id_q;
	assign time_needed = time_needed_q;
	assign finished    = finished_q;
	assign time_left   = time_left_q;
	assign queue_empty = queue_empty_q;

endmodule

/* rtl/core/round_robin_dispatcher_unit.sv */
// Top level of the round-robin time-slice dispatcher.
//
//   channel   direction  handshake            payload
//   in        input      in_valid / in_stall  op, job_id, service_time
//   out       output     out_valid / out_stall kind, run_id, time_needed, finished,
//                                             time_left, queue_empty
//   cfg       input      cfg_we               cfg_wdata (quantum)
//
// An enqueue beat that finds room is taken in S_IDLE and the next beat is taken at once.
// A slice beat first reads the head entry into a register, then in S_READ does the
// compare and subtract against the quantum and the write-back at the tail.
// A beat on a full queue (enqueue) or an empty queue (slice) passes through S_FULL or S_EMPTY.
// The result register frees the input side; a stalled result holds the block only
// when a later beat must load a new result, and then for as long as out_stall stays high.
// Reset empties the queue and sets the quantum to one; queue contents need no clearing.
`include "round_robin_dispatcher_unit_assert.svh"

module round_robin_dispatcher_unit
	import rrd_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [7:0]  job_id,
	input  logic [15:0] service_time,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [7:0]  run_id,
	output logic [15:0] time_needed,
	output logic        finished,
	output logic [15:0] time_left,
	output logic        queue_empty
);

	rrd_cmd_t  cmd;
	rrd_stat_t stat;

	// The controller sequences each beat; it never touches payload itself.
	rrd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.op       (op),
		.stat     (stat),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	// The datapath owns the job memory, the queue pointers and the result register.
	rrd_dpath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.job_id       (job_id),
		.service_time (service_time),
		.cmd          (cmd),
		.stat         (stat),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.kind         (kind),
		.run_id       (run_id),
		.time_needed  (time_needed),
		.finished     (finished),
		.time_left    (time_left),
		.queue_empty  (queue_empty)
	);

	// A taken slice beat always leaves the block busy, with the input side stalled.
	`RRD_ASSERT_NXT(a_slice_busy, clk, arst_n, in_valid && !in_stall && (op == OP_SLICE), in_stall, "slice beat did not hold the input side")

	// A finished job has nothing left to run.
	`RRD_ASSERT_IMP(a_fin_zero, clk, arst_n, out_valid && (kind == KIND_DISPATCH) && finished, time_left == 16'd0, "finished job reports time left")

	// An empty report leaves the queue empty and names no job.
	`RRD_ASSERT_IMP(a_empty_rep, clk, arst_n, out_valid && (kind == KIND_EMPTY), queue_empty && (run_id == 8'd0), "empty report is inconsistent")

	// A dropped enqueue can only come from a full queue.
	`RRD_ASSERT_IMP(a_full_rep, clk, arst_n, out_valid && (kind == KIND_FULL), !queue_empty && !finished, "full report is inconsistent")

endmodule
